### design/hla_pkg.sv
// Shared types, constants and the trig table for the Hough line accumulator.
// No dependencies.
package hla_pkg;

  localparam int ANGLES         = 180;
  localparam int RHO_BINS       = 1024;
  localparam int COUNT_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 14;
  localparam int ANG_W          = 8;
  localparam int RHO_W          = 10;
  localparam int ADDR_W         = ANG_W + RHO_W;
  localparam int ACC_DEPTH      = ANGLES * RHO_BINS;
  localparam int PC_W           = 20;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;

  localparam logic [1:0] MODE_VOTE   = 2'd0;
  localparam logic [1:0] MODE_UNVOTE = 2'd1;
  localparam logic [1:0] MODE_FIND   = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  localparam logic [1:0] REG_WIDTH    = 2'd0;
  localparam logic [1:0] REG_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_RHO_HALF = 2'd2;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef struct packed {
    logic              clr;
    logic [ADDR_W-1:0] clr_addr;
    logic              load;
    logic              step;
    logic [ANG_W-1:0]  angle;
    logic [RHO_W-1:0]  rho;
  } cmd_t;

  typedef struct packed {
    logic             pc_zero;
    logic [RHO_W-1:0] span;
  } sts_t;

  typedef logic [ANGLES-1:0][2*TRIG_W-1:0] trig_tab_t;

  function automatic longint unsigned round_q30(longint v);
    longint unsigned u;
    if (v < 0) v = 0;
    u = longint'(v) + (64'd1 << (29 - TRIG_FRAC_BITS));
    return u >> (30 - TRIG_FRAC_BITS);
  endfunction

  // restoring long division, quotient truncated
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic trig_tab_t trig_table();
    trig_tab_t       tab;
    longint unsigned a, x, x2, ts, tc, cr, sr;
    longint          s, c;
    logic            upper;
    for (int t = 0; t < ANGLES; t++) begin
      if (2 * t == ANGLES) begin
        tab[t] = {TRIG_W'(0), TRIG_W'(64'd1 << TRIG_FRAC_BITS)};
      end else begin
        upper = (2 * t > ANGLES);
        a = upper ? longint'(ANGLES - t) : longint'(t);
        x = (a * PI_Q30) / ANGLES;
        x2 = (x * x) >> 30;
        ts = x;
        tc = 64'd1 << 30;
        s = longint'(ts);
        c = longint'(tc);
        for (int k = 1; k <= 12; k++) begin
          ts = udiv64((ts * x2) >> 30, longint'((2 * k) * (2 * k + 1)));
          tc = udiv64((tc * x2) >> 30, longint'((2 * k - 1) * (2 * k)));
          if (k % 2 == 1) begin
            s -= longint'(ts);
            c -= longint'(tc);
          end else begin
            s += longint'(ts);
            c += longint'(tc);
          end
        end
        cr = round_q30(c);
        sr = round_q30(s);
        tab[t][2*TRIG_W-1:TRIG_W] = upper ? TRIG_W'(-longint'(cr)) : TRIG_W'(cr);
        tab[t][TRIG_W-1:0]        = TRIG_W'(sr);
      end
    end
    return tab;
  endfunction

  localparam trig_tab_t TRIG_ROM = trig_table();

endpackage

### design/hla_ctrl.sv
// Controller state machine: clearing sweep, per-angle and scan sequencing, output handshake.
// Depends on hla_pkg.
module hla_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     mode_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  hla_pkg::sts_t  sts_i,
  output hla_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_VOTE  = 3'd2;
  localparam logic [2:0] S_FIND  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]                   state_q, state_d;
  logic [hla_pkg::ANG_W-1:0]    t_q, t_d;
  logic [hla_pkg::RHO_W-1:0]    r_q, r_d;
  logic [hla_pkg::ADDR_W-1:0]   clr_q, clr_d;
  logic [1:0]                   drn_q, drn_d;
  logic                         accept;
  logic                         t_last;

  assign accept = (state_q == S_IDLE) && in_valid_i;
  assign t_last = (t_q == hla_pkg::ANG_W'(hla_pkg::ANGLES - 1));

  always_comb begin
    state_d = state_q;
    t_d     = t_q;
    r_d     = r_q;
    clr_d   = clr_q;
    drn_d   = drn_q;
    cmd_o          = '0;
    cmd_o.clr_addr = clr_q;
    cmd_o.angle    = t_q;
    cmd_o.rho      = r_q;
    in_stall_o  = (state_q != S_IDLE);
    out_valid_o = (state_q == S_OUT);
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == hla_pkg::ADDR_W'(hla_pkg::ACC_DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          t_d = '0;
          r_d = '0;
          drn_d = 2'd3;
          case (mode_i)
            hla_pkg::MODE_VOTE, hla_pkg::MODE_UNVOTE: state_d = S_VOTE;
            hla_pkg::MODE_FIND: begin
              state_d = (sts_i.pc_zero || sts_i.span == '0) ? S_DRAIN : S_FIND;
            end
            default: state_d = S_READ;
          endcase
        end
      end
      S_VOTE: begin
        cmd_o.step = 1'b1;
        t_d = t_q + 1'b1;
        if (t_last) state_d = S_DRAIN;
      end
      S_FIND: begin
        cmd_o.step = 1'b1;
        t_d = t_q + 1'b1;
        if (t_last) begin
          t_d = '0;
          r_d = r_q + 1'b1;
          if (r_q == sts_i.span - 1'b1) state_d = S_DRAIN;
        end
      end
      S_READ: begin
        cmd_o.step = 1'b1;
        state_d = S_DRAIN;
      end
      S_DRAIN: begin
        drn_d = drn_q - 1'b1;
        if (drn_q == 2'd0) state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      t_q     <= '0;
      r_q     <= '0;
      clr_q   <= '0;
      drn_q   <= '0;
    end else begin
      state_q <= state_d;
      t_q     <= t_d;
      r_q     <= r_d;
      clr_q   <= clr_d;
      drn_q   <= drn_d;
    end
  end

endmodule

### design/hla_datapath.sv
// Datapath: config registers, vote pipeline, accumulator memory, scan compare, result registers.
// Depends on hla_pkg.
module hla_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [9:0]                    cfg_data_i,
  input  logic [1:0]                    mode_i,
  input  logic [9:0]                    pixel_x_i,
  input  logic [9:0]                    pixel_y_i,
  input  logic [7:0]                    query_angle_i,
  input  logic [9:0]                    query_rho_i,
  input  hla_pkg::cmd_t                 cmd_i,
  output hla_pkg::sts_t                 sts_o,
  output logic [7:0]                    angle_index_o,
  output logic [9:0]                    rho_index_o,
  output logic signed [15:0]            bin_value_o,
  output logic                          status_o
);

  localparam int CW = hla_pkg::COUNT_BITS;
  localparam int TW = hla_pkg::TRIG_W;
  localparam int PW = TW + 11;
  localparam int SW = PW + 1;
  localparam int FB = hla_pkg::TRIG_FRAC_BITS;

  logic [9:0]  width_q, height_q;
  logic [8:0]  rho_half_q;
  logic [hla_pkg::PC_W-1:0] pc_q;
  logic [1:0]  mode_q;
  logic [7:0]  qa_q;
  logic [9:0]  qr_q;
  logic signed [10:0] dx_q, dy_q;

  logic signed [CW-1:0] mem [hla_pkg::ACC_DEPTH];
  logic signed [CW-1:0] rd_q;

  logic                  v1_q;
  logic [7:0]            t1_q;
  logic signed [PW-1:0]  pc1_q, ps1_q;
  logic signed [TW-1:0]  cos_w, sin_w;
  logic signed [SW-1:0]  sum_w, adj_w;
  logic signed [SW-FB-1:0] tr_w;
  logic signed [SW-FB:0] rho_w;
  logic                  in_rng;
  logic                  v2_q, v3_q;
  logic [hla_pkg::ADDR_W-1:0] a2_q, a3_q;
  logic                  f1_q, f2_q;
  logic [7:0]            ft1_q, ft2_q;
  logic [9:0]            fr1_q, fr2_q;
  logic signed [CW:0]    inc_w;
  logic signed [CW-1:0]  sat_w;
  logic                  mem_we, mem_re;
  logic [hla_pkg::ADDR_W-1:0] mem_wa, mem_ra;
  logic signed [CW-1:0]  mem_wd;

  logic [7:0]            ang_q;
  logic [9:0]            rho_q;
  logic signed [CW-1:0]  val_q;
  logic                  stat_q;

  assign sts_o.pc_zero = (pc_q == '0);
  assign sts_o.span    = {rho_half_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= 10'd640;
      height_q   <= 10'd480;
      rho_half_q <= 9'd452;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hla_pkg::REG_WIDTH:    width_q    <= cfg_data_i;
        hla_pkg::REG_HEIGHT:   height_q   <= cfg_data_i;
        hla_pkg::REG_RHO_HALF: rho_half_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else if (cmd_i.load && mode_i == hla_pkg::MODE_VOTE && !(&pc_q)) begin
      pc_q <= pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      qa_q   <= query_angle_i;
      qr_q   <= query_rho_i;
      dx_q   <= $signed({1'b0, pixel_x_i}) - $signed({2'b0, width_q[9:1]});
      dy_q   <= $signed({1'b0, pixel_y_i}) - $signed({2'b0, height_q[9:1]});
    end
  end

  // vote stage 1: products
  assign cos_w = $signed(hla_pkg::TRIG_ROM[cmd_i.angle][2*TW-1:TW]);
  assign sin_w = $signed(hla_pkg::TRIG_ROM[cmd_i.angle][TW-1:0]);

  // vote stage 2: truncate toward zero, offset, range check
  assign sum_w  = SW'(pc1_q) + SW'(ps1_q);
  assign adj_w  = sum_w + (sum_w[SW-1] ? SW'((1 << FB) - 1) : SW'(0));
  assign tr_w   = adj_w[SW-1:FB];
  assign rho_w  = (SW-FB+1)'(tr_w) + $signed({1'b0, rho_half_q});
  assign in_rng = !rho_w[SW-FB] && (rho_w < $signed({1'b0, rho_half_q, 1'b0}));

  // vote stage 3: saturating update
  assign inc_w = (CW+1)'(rd_q) + ((mode_q == hla_pkg::MODE_VOTE) ? (CW+1)'(1) : -(CW+1)'(1));
  assign sat_w = (inc_w > (CW+1)'((1 << (CW-1)) - 1)) ? CW'((1 << (CW-1)) - 1) :
                 (inc_w < -(CW+1)'(1 << (CW-1)))      ? CW'(1 << (CW-1)) : inc_w[CW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      f1_q <= 1'b0;
      f2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.step && (mode_q == hla_pkg::MODE_VOTE || mode_q == hla_pkg::MODE_UNVOTE);
      v2_q <= v1_q && in_rng;
      v3_q <= v2_q;
      f1_q <= cmd_i.step && (mode_q == hla_pkg::MODE_FIND ||
              (mode_q == hla_pkg::MODE_READ && qa_q < 8'(hla_pkg::ANGLES)));
      f2_q <= f1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q  <= cmd_i.angle;
    pc1_q <= dx_q * cos_w;
    ps1_q <= dy_q * sin_w;
    a2_q  <= {t1_q, rho_w[9:0]};
    a3_q  <= a2_q;
    ft1_q <= (mode_q == hla_pkg::MODE_READ) ? qa_q : cmd_i.angle;
    fr1_q <= (mode_q == hla_pkg::MODE_READ) ? qr_q : cmd_i.rho;
    ft2_q <= ft1_q;
    fr2_q <= fr1_q;
  end

  always_comb begin
    mem_we = cmd_i.clr || v3_q;
    mem_wa = cmd_i.clr ? cmd_i.clr_addr : a3_q;
    mem_wd = cmd_i.clr ? '0 : sat_w;
    mem_re = v2_q || f1_q;
    mem_ra = v2_q ? a2_q : {ft1_q, fr1_q};
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ang_q  <= (mode_i == hla_pkg::MODE_READ) ? query_angle_i : '0;
      rho_q  <= (mode_i == hla_pkg::MODE_READ) ? query_rho_i : '0;
      val_q  <= '0;
      stat_q <= (mode_i == hla_pkg::MODE_FIND) && (pc_q == '0);
    end else if (f2_q) begin
      if (mode_q == hla_pkg::MODE_READ) begin
        val_q <= rd_q;
      end else if (rd_q > val_q) begin
        val_q <= rd_q;
        ang_q <= ft2_q;
        rho_q <= fr2_q;
      end
    end
  end

  assign angle_index_o = ang_q;
  assign rho_index_o   = rho_q;
  assign bin_value_o   = val_q;
  assign status_o      = stat_q;

endmodule

### design/hough_line_accumulator.sv
// Top level of the Hough line accumulator: controller plus datapath.
// Find highest skips the scan when nothing is voted or rho_half is zero.
// One item at a time; a vote walks one angle per cycle, reading and writing the accumulator
// memory through its separate read and write ports.
// Reset: asynchronous, active low; a clearing pass then zeroes the accumulator,
// during which in_stall_o stays high. Config writes are always taken.
module hough_line_accumulator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [9:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [9:0]         pixel_x_i,
  input  logic [9:0]         pixel_y_i,
  input  logic [7:0]         query_angle_i,
  input  logic [9:0]         query_rho_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         angle_index_o,
  output logic [9:0]         rho_index_o,
  output logic signed [15:0] bin_value_o,
  output logic               status_o
);

  hla_pkg::cmd_t cmd;
  hla_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  hla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hla_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mode_i        (mode_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .query_angle_i (query_angle_i),
    .query_rho_i   (query_rho_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .angle_index_o (angle_index_o),
    .rho_index_o   (rho_index_o),
    .bin_value_o   (bin_value_o),
    .status_o      (status_o)
  );

endmodule

### tb/hough_line_accumulator_tb.sv
// Self-checking testbench for hough_line_accumulator: queue-fed driver, clocked monitor,
// and an in-bench predictor of the accumulator, vote count and trig table.
// Depends on hla_pkg and the hough_line_accumulator RTL.
module hough_line_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int HOLD_LEN = 3000;

  typedef struct {
    logic [1:0] mode;
    logic [9:0] px;
    logic [9:0] py;
    logic [7:0] qa;
    logic [9:0] qr;
  } vote_item_t;

  typedef struct packed {
    logic [7:0]        ang;
    logic [9:0]        rho;
    logic signed [15:0] val;
    logic              st;
  } bin_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [9:0]         cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         mode_i = '0;
  logic [9:0]         pixel_x_i = '0;
  logic [9:0]         pixel_y_i = '0;
  logic [7:0]         query_angle_i = '0;
  logic [9:0]         query_rho_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [7:0]         angle_index_o;
  logic [9:0]         rho_index_o;
  logic signed [15:0] bin_value_o;
  logic               status_o;

  hough_line_accumulator uut (.*);

  vote_item_t  pend_items[$];
  bin_result_t bins_due[$];
  int          errors = 0;
  int          snd_idle = 37;
  int          rcv_idle = 54;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          hold_cnt = 0;

  int          acc[hla_pkg::ACC_DEPTH];
  int          cos_q[hla_pkg::ANGLES];
  int          sin_q[hla_pkg::ANGLES];
  int unsigned votes_cast = 0;
  int unsigned cur_w = 640;
  int unsigned cur_h = 480;
  int unsigned cur_rh = 452;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #12_000_000;
    $display("hough_line_accumulator_tb: done, errors");
    $finish;
  end

  function automatic longint q30_to_q14(longint v);
    if (v < 0) v = 0;
    return (v + (longint'(1) << 15)) >>> 16;
  endfunction

  function automatic void build_trig();
    longint unsigned a, x, x2, ts, tc;
    longint          s, c;
    bit              upper;
    for (int t = 0; t < hla_pkg::ANGLES; t++) begin
      if (2 * t == hla_pkg::ANGLES) begin
        cos_q[t] = 0;
        sin_q[t] = 1 << hla_pkg::TRIG_FRAC_BITS;
      end else begin
        upper = (2 * t > hla_pkg::ANGLES);
        a = longint'(upper ? hla_pkg::ANGLES - t : t);
        x = (a * hla_pkg::PI_Q30) / hla_pkg::ANGLES;
        x2 = (x * x) >> 30;
        ts = x;
        tc = 64'd1 << 30;
        s = longint'(ts);
        c = longint'(tc);
        for (int k = 1; k <= 12; k++) begin
          ts = ((ts * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
          tc = ((tc * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
          if (k % 2 == 1) begin
            s -= longint'(ts);
            c -= longint'(tc);
          end else begin
            s += longint'(ts);
            c += longint'(tc);
          end
        end
        cos_q[t] = upper ? -int'(q30_to_q14(c)) : int'(q30_to_q14(c));
        sin_q[t] = int'(q30_to_q14(s));
      end
    end
  endfunction

  function automatic void tally_votes(int unsigned px, int unsigned py, int d);
    longint dx, dy, p, tr, r, v;
    dx = longint'(px) - longint'(cur_w / 2);
    dy = longint'(py) - longint'(cur_h / 2);
    for (int t = 0; t < hla_pkg::ANGLES; t++) begin
      p = dx * longint'(cos_q[t]) + dy * longint'(sin_q[t]);
      tr = (p < 0) ? -((-p) >>> hla_pkg::TRIG_FRAC_BITS) : (p >>> hla_pkg::TRIG_FRAC_BITS);
      r = tr + longint'(cur_rh);
      if (r >= 0 && r < 2 * longint'(cur_rh) && r < hla_pkg::RHO_BINS) begin
        v = longint'(acc[t * hla_pkg::RHO_BINS + int'(r)]) + longint'(d);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        acc[t * hla_pkg::RHO_BINS + int'(r)] = int'(v);
      end
    end
  endfunction

  function automatic bin_result_t predict_bin(vote_item_t it);
    bin_result_t res;
    int unsigned span;
    int          best;
    res = '0;
    best = 0;
    case (it.mode)
      hla_pkg::MODE_VOTE: begin
        tally_votes(32'(it.px), 32'(it.py), 1);
        if (votes_cast < 1048575) votes_cast++;
      end
      hla_pkg::MODE_UNVOTE: tally_votes(32'(it.px), 32'(it.py), -1);
      hla_pkg::MODE_FIND: begin
        if (votes_cast == 0) begin
          res.st = 1'b1;
        end else begin
          span = 2 * cur_rh;
          if (span > hla_pkg::RHO_BINS) span = hla_pkg::RHO_BINS;
          for (int r = 0; r < span; r++)
            for (int t = 0; t < hla_pkg::ANGLES; t++)
              if (acc[t * hla_pkg::RHO_BINS + r] > best) begin
                best = acc[t * hla_pkg::RHO_BINS + r];
                res.ang = 8'(t);
                res.rho = 10'(r);
              end
          res.val = 16'(best);
        end
      end
      default: begin
        res.ang = it.qa;
        res.rho = it.qr;
        if (it.qa < hla_pkg::ANGLES)
          res.val = 16'(acc[int'(it.qa) * hla_pkg::RHO_BINS + int'(it.qr)]);
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i) begin
    vote_item_t it;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        it.mode = mode_i;
        it.px = pixel_x_i;
        it.py = pixel_y_i;
        it.qa = query_angle_i;
        it.qr = query_rho_i;
        bins_due = {bins_due, predict_bin(it)};
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pend_items.size() > 0 && $urandom_range(99) >= snd_idle) begin
          it = pend_items.pop_front();
          mode_i <= it.mode;
          pixel_x_i <= it.px;
          pixel_y_i <= it.py;
          query_angle_i <= it.qa;
          query_rho_i <= it.qr;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    bin_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (bins_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %0d %0d %0d %0d",
            angle_index_o, rho_index_o, bin_value_o, status_o);
        end else begin
          want = bins_due.pop_front();
          if (angle_index_o !== want.ang || rho_index_o !== want.rho ||
              bin_value_o !== want.val || status_o !== want.st) begin
            errors++;
            if (errors <= 10) $display("mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
              want.ang, want.rho, want.val, want.st,
              angle_index_o, rho_index_o, bin_value_o, status_o);
          end
        end
      end
      if (hold_seen != hold_reqs) begin
        hold_seen <= hold_reqs;
        hold_cnt <= HOLD_LEN;
        out_stall_i <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rcv_idle);
      end
    end
  end

  task automatic push_item(logic [1:0] m, int px, int py, int qa, int qr);
    vote_item_t it;
    it.mode = m;
    it.px = px[9:0];
    it.py = py[9:0];
    it.qa = qa[7:0];
    it.qr = qr[9:0];
    pend_items = {pend_items, it};
  endtask

  task automatic drain();
    while (pend_items.size() > 0 || bins_due.size() > 0 || in_valid_i) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      hla_pkg::REG_WIDTH:    cur_w = 32'(data);
      hla_pkg::REG_HEIGHT:   cur_h = 32'(data);
      hla_pkg::REG_RHO_HALF: cur_rh = 32'(data[8:0]);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_geometry(int w, int h, int rh);
    write_reg(hla_pkg::REG_WIDTH, w[9:0]);
    write_reg(hla_pkg::REG_HEIGHT, h[9:0]);
    write_reg(hla_pkg::REG_RHO_HALF, rh[9:0]);
    write_reg(REG_SPARE, 10'($urandom));
  endtask

  task automatic random_items(int n, bit finds);
    int sel, px, py, span;
    span = 2 * cur_rh + 2;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if ($urandom_range(3) == 0) begin
        px = $urandom_range(1023);
        py = $urandom_range(1023);
      end else begin
        px = cur_w / 2 + $urandom_range(span + 2) - span / 2 - 1;
        py = cur_h / 2 + $urandom_range(span + 2) - span / 2 - 1;
      end
      if (finds && sel < 3)
        push_item(hla_pkg::MODE_FIND, px, py, $urandom_range(255), $urandom_range(1023));
      else if (sel < 58)
        push_item(hla_pkg::MODE_VOTE, px, py, $urandom_range(255), $urandom_range(1023));
      else if (sel < 73)
        push_item(hla_pkg::MODE_UNVOTE, px, py, $urandom_range(255), $urandom_range(1023));
      else if (sel < 90)
        push_item(hla_pkg::MODE_READ, px, py, $urandom_range(hla_pkg::ANGLES - 1),
                  $urandom_range(span > 1023 ? 1023 : span));
      else
        push_item(hla_pkg::MODE_READ, px, py, $urandom_range(255), $urandom_range(1023));
    end
  endtask

  task automatic run_phase(int w, int h, int rh, int n, bit finds);
    set_geometry(w, h, rh);
    random_items(n / 2, finds);
    drain();
    random_items(n - n / 2, finds);
    drain();
  endtask

  initial begin
    build_trig();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(hla_pkg::REG_RHO_HALF, 10'd4);
    push_item(hla_pkg::MODE_FIND, 0, 0, 0, 0);
    push_item(hla_pkg::MODE_READ, 0, 0, 0, 0);
    push_item(hla_pkg::MODE_READ, 0, 0, hla_pkg::ANGLES - 1, 1023);
    push_item(hla_pkg::MODE_READ, 0, 0, 255, 5);
    push_item(hla_pkg::MODE_UNVOTE, 320, 240, 0, 0);
    push_item(hla_pkg::MODE_FIND, 0, 0, 0, 0);
    push_item(hla_pkg::MODE_READ, 0, 0, 0, 4);
    push_item(hla_pkg::MODE_VOTE, 0, 0, 0, 0);
    push_item(hla_pkg::MODE_VOTE, 1023, 1023, 0, 0);
    push_item(hla_pkg::MODE_VOTE, 320, 240, 0, 0);
    push_item(hla_pkg::MODE_VOTE, 320, 240, 0, 0);
    push_item(hla_pkg::MODE_VOTE, 321, 241, 0, 0);
    push_item(hla_pkg::MODE_FIND, 0, 0, 0, 0);
    push_item(hla_pkg::MODE_READ, 0, 0, 0, 4);
    push_item(hla_pkg::MODE_READ, 0, 0, 90, 4);
    drain();
    set_geometry(1, 1, 512);
    push_item(hla_pkg::MODE_VOTE, 0, 0, 0, 0);
    push_item(hla_pkg::MODE_FIND, 0, 0, 0, 0);
    drain();
    set_geometry(720, 720, 511);
    push_item(hla_pkg::MODE_VOTE, 0, 0, 0, 0);
    push_item(hla_pkg::MODE_VOTE, 719, 719, 0, 0);
    push_item(hla_pkg::MODE_UNVOTE, 360, 360, 0, 0);
    push_item(hla_pkg::MODE_READ, 0, 0, 45, 1021);
    push_item(hla_pkg::MODE_READ, 0, 0, 135, 0);
    drain();

    run_phase(640, 480, 6, 300, 1'b1);
    run_phase(720, 720, 511, 150, 1'b0);
    run_phase(1, 1, 1, 100, 1'b1);
    snd_idle = 54;
    rcv_idle = 37;
    hold_reqs++;
    run_phase($urandom_range(1, 720), $urandom_range(1, 720), 8, 300, 1'b1);
    run_phase(1023, 1023, 3, 150, 1'b1);
    snd_idle = 0;
    rcv_idle = 0;
    run_phase(640, 480, 452, 250, 1'b0);

    drain();
    repeat (200) @(posedge clk_i);
    if (bins_due.size() != 0) errors++;
    if (errors == 0) begin
      $display("hough_line_accumulator_tb: done, clean");
    end else begin
      $display("hough_line_accumulator_tb: done, errors");
    end
    $finish;
  end

endmodule
